[rtl/hfa_pkg.sv]
// Shared constants, control structs and log helpers for the half-fit allocator.
// No dependencies; used by hfa_store and half_fit_allocator.
`default_nettype none
package hfa_pkg;

	localparam int NUM_BLOCKS_DEF  = 1024;
	localparam int BLOCK_BYTES_DEF = 32;
	localparam int NUM_BUCKETS_DEF = 11;
	localparam int HDR_BYTES       = 4;
	localparam int OFF_W           = 15;
	localparam int STAT_W          = 2;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_SIZE  = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOFIT = 2'd2;

	// header memory port control, one write-enable per field
	typedef struct packed {
		logic rd;
		logic wr;
		logic m_prev;
		logic m_next;
		logic m_size;
		logic m_alloc;
	} hdr_ctl_t;

	// link memory port control, one write-enable per half (back / forward)
	typedef struct packed {
		logic rd;
		logic wr;
		logic m_prev;
		logic m_next;
	} lnk_ctl_t;

	function automatic int floor_log2(logic [31:0] v);
		int r;
		r = 0;
		for (int k = 0; k < 32; k++) begin
			if (v[k])
				r = k;
		end
		return r;
	endfunction

	function automatic int bucket_of(logic [31:0] v, int nb);
		int b;
		b = floor_log2(v);
		return (b >= nb) ? nb - 1 : b;
	endfunction

endpackage
`default_nettype wire

[rtl/hfa_store.sv]
// Header and free-link memories of the half-fit allocator, with registered reads.
// Field-masked writes; depends on hfa_pkg.
`default_nettype none
module hfa_store #(
	parameter int IW = 10
) (
	input  wire logic              clk,
	input  wire hfa_pkg::hdr_ctl_t hc,
	input  wire logic [IW-1:0]     h_ra,
	input  wire logic [IW-1:0]     h_wa,
	input  wire logic [3*IW:0]     h_wd,
	output logic      [3*IW:0]     h_rd,
	input  wire hfa_pkg::lnk_ctl_t lc,
	input  wire logic [IW-1:0]     l_ra,
	input  wire logic [IW-1:0]     l_wa,
	input  wire logic [2*IW+1:0]   l_wd,
	output logic      [2*IW+1:0]   l_rd
);

	localparam int DEPTH = 1 << IW;

	// header entry: prev, next, size-1, alloc
	logic [3*IW:0]   hmem [DEPTH];
	// link entry: back valid, back index, forward valid, forward index
	logic [2*IW+1:0] lmem [DEPTH];

	always_ff @(posedge clk) begin
		if (hc.wr) begin
			if (hc.m_prev)
				hmem[h_wa][3*IW -: IW] <= h_wd[3*IW -: IW];
			if (hc.m_next)
				hmem[h_wa][2*IW -: IW] <= h_wd[2*IW -: IW];
			if (hc.m_size)
				hmem[h_wa][IW -: IW] <= h_wd[IW -: IW];
			if (hc.m_alloc)
				hmem[h_wa][0] <= h_wd[0];
		end
		if (hc.rd)
			h_rd <= hmem[h_ra];
	end

	always_ff @(posedge clk) begin
		if (lc.wr) begin
			if (lc.m_prev)
				lmem[l_wa][2*IW+1 -: IW+1] <= l_wd[2*IW+1 -: IW+1];
			if (lc.m_next)
				lmem[l_wa][IW:0] <= l_wd[IW:0];
		end
		if (lc.rd)
			l_rd <= lmem[l_ra];
	end

endmodule
`default_nettype wire

[rtl/half_fit_allocator.sv]
// Half-fit allocator: top-level sequencer over the header and link memories.
// One request is in work at a time; a new one is taken only after the last has
// passed through its dependent reads and writes and its result is loaded.
// After reset a clearing sweep over every block initializes both memories;
// no request is taken until it ends. Depends on hfa_pkg and hfa_store.
`default_nettype none
module half_fit_allocator #(
	parameter int NUM_BLOCKS  = hfa_pkg::NUM_BLOCKS_DEF,
	parameter int BLOCK_BYTES = hfa_pkg::BLOCK_BYTES_DEF,  // power of two
	parameter int NUM_BUCKETS = hfa_pkg::NUM_BUCKETS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        mode,
	input  wire logic [hfa_pkg::OFF_W-1:0]   request_bytes,
	input  wire logic [hfa_pkg::OFF_W-1:0]   release_offset,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic      [hfa_pkg::STAT_W-1:0]  status,
	output logic      [hfa_pkg::OFF_W-1:0]   payload_offset
);

	localparam int IW   = $clog2(NUM_BLOCKS);
	localparam int BW   = IW + 1;                 // block counts up to NUM_BLOCKS
	localparam int BKW  = $clog2(NUM_BUCKETS);
	localparam int SH   = $clog2(BLOCK_BYTES);
	localparam int HDR  = hfa_pkg::HDR_BYTES;
	localparam int HEAP = NUM_BLOCKS * BLOCK_BYTES;
	localparam int HW   = 3 * IW + 1;
	localparam int LW   = 2 * IW + 2;
	localparam int RST_BKT = hfa_pkg::bucket_of(32'(NUM_BLOCKS), NUM_BUCKETS);

	// sequencer states
	localparam logic [4:0] S_CLR    = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_DEC    = 5'd2;
	localparam logic [4:0] S_A_CHK  = 5'd3;
	localparam logic [4:0] S_A_SPL  = 5'd4;
	localparam logic [4:0] S_A_SPL2 = 5'd5;
	localparam logic [4:0] S_F_I    = 5'd6;
	localparam logic [4:0] S_F_P    = 5'd7;
	localparam logic [4:0] S_F_RN   = 5'd8;
	localparam logic [4:0] S_F_N    = 5'd9;
	localparam logic [4:0] S_F_H1   = 5'd10;
	localparam logic [4:0] S_F_H2   = 5'd11;
	localparam logic [4:0] S_RM1    = 5'd12;
	localparam logic [4:0] S_RM2    = 5'd13;
	localparam logic [4:0] S_RM3    = 5'd14;
	localparam logic [4:0] S_INS1   = 5'd15;
	localparam logic [4:0] S_INS2   = 5'd16;
	localparam logic [4:0] S_DONE   = 5'd17;

	// control state
	logic [4:0]             state_q, state_d;
	logic [4:0]             ret_q, ret_d;     // where a list removal returns
	logic [IW-1:0]          clr_q;
	logic [NUM_BUCKETS-1:0] nonempty_q, nonempty_d;
	logic [IW-1:0]          heads_q [NUM_BUCKETS];
	logic                   head_we;
	logic [BKW-1:0]         head_wa;
	logic [IW-1:0]          head_wd;
	logic                   out_valid_q;

	// working registers of the request in flight
	logic                          mode_q;
	logic [hfa_pkg::OFF_W-1:0]     bytes_q, off_q;
	logic [IW-1:0]                 cur_q, nxt_q, p_q, start_q, nn_q;
	logic [BW-1:0]                 blocks_q, rem_q, sz_q;
	logic                          first_q, last_q, mrg_n_q;
	logic [IW-1:0]                 rm_x_q, ins_x_q, ins_h_q;
	logic [BW-1:0]                 rm_size_q, ins_size_q;
	logic [hfa_pkg::STAT_W-1:0]    res_st_q, stat_q;
	logic [hfa_pkg::OFF_W-1:0]     res_off_q, poff_q;

	// memory ports
	hfa_pkg::hdr_ctl_t hc;
	hfa_pkg::lnk_ctl_t lc;
	logic [IW-1:0]     h_ra, h_wa, l_ra, l_wa;
	logic [HW-1:0]     h_wd, h_rd;
	logic [LW-1:0]     l_wd, l_rd;

	hfa_store #(.IW(IW)) u_store (
		.clk  (clk),
		.hc   (hc),
		.h_ra (h_ra),
		.h_wa (h_wa),
		.h_wd (h_wd),
		.h_rd (h_rd),
		.lc   (lc),
		.l_ra (l_ra),
		.l_wa (l_wa),
		.l_wd (l_wd),
		.l_rd (l_rd)
	);

	// fields of the last header / link read
	logic [IW-1:0] h_prev, h_next, h_size;
	logic          h_alloc;
	logic          l_pv, l_nv;
	logic [IW-1:0] l_prev, l_next;
	logic [BW-1:0] h_cnt;   // size in blocks of the header just read

	assign h_prev  = h_rd[3*IW -: IW];
	assign h_next  = h_rd[2*IW -: IW];
	assign h_size  = h_rd[IW -: IW];
	assign h_alloc = h_rd[0];
	assign l_pv    = l_rd[2*IW+1];
	assign l_prev  = l_rd[2*IW -: IW];
	assign l_nv    = l_rd[IW];
	assign l_next  = l_rd[IW-1:0];
	assign h_cnt   = {1'b0, h_size} + BW'(1);

	// request decode
	logic [16:0]   blk_full;
	logic [BW-1:0] blocks_d;
	int            need_d;
	logic          bad_size, fnd;
	logic [BKW-1:0] fb;
	logic [15:0]   diff;
	logic          bad_off;
	logic [IW-1:0] idx_d;
	logic [IW-1:0] nb;
	logic [BKW-1:0] rm_bkt, ins_bkt;
	logic [IW-1:0] fh_next;

	always_comb begin
		blk_full = ((17'(bytes_q) + 17'(HDR - 1)) >> SH) + 17'd1;
		blocks_d = BW'(blk_full);
		need_d   = (blocks_d > BW'(1)) ? hfa_pkg::floor_log2(32'(blocks_d - BW'(1))) + 1 : 0;
		bad_size = (bytes_q == '0) || (32'(bytes_q) > 32'(HEAP - HDR)) ||
			(need_d >= NUM_BUCKETS);
		// lowest nonempty bucket at or above the needed one
		fnd = 1'b0;
		fb  = '0;
		for (int k = NUM_BUCKETS - 1; k >= 0; k--) begin
			if (nonempty_q[k] && (k >= need_d)) begin
				fnd = 1'b1;
				fb  = BKW'(k);
			end
		end
		diff    = 16'(off_q) - 16'(HDR);
		bad_off = (off_q < hfa_pkg::OFF_W'(HDR)) || ((diff & 16'(BLOCK_BYTES - 1)) != '0) ||
			((diff >> SH) >= 16'(NUM_BLOCKS));
		idx_d   = IW'(diff >> SH);
	end

	assign nb      = cur_q + blocks_q[IW-1:0];
	assign rm_bkt  = BKW'(hfa_pkg::bucket_of(32'(rm_size_q), NUM_BUCKETS));
	assign ins_bkt = BKW'(hfa_pkg::bucket_of(32'(ins_size_q), NUM_BUCKETS));
	// forward link of the merged block
	assign fh_next = mrg_n_q ? ((nn_q == nxt_q) ? start_q : nn_q) :
		(last_q ? start_q : nxt_q);

	// sequencer: one memory access per port per cycle
	always_comb begin
		state_d    = state_q;
		ret_d      = ret_q;
		nonempty_d = nonempty_q;
		head_we    = 1'b0;
		head_wa    = '0;
		head_wd    = '0;
		hc         = '0;
		lc         = '0;
		h_ra       = '0;
		h_wa       = '0;
		h_wd       = '0;
		l_ra       = '0;
		l_wa       = '0;
		l_wd       = '0;
		case (state_q)
			S_CLR: begin
				// sweep: block 0 spans the heap, everything else zero
				hc   = '{rd: 1'b0, wr: 1'b1, m_prev: 1'b1, m_next: 1'b1,
					m_size: 1'b1, m_alloc: 1'b1};
				lc   = '{rd: 1'b0, wr: 1'b1, m_prev: 1'b1, m_next: 1'b1};
				h_wa = clr_q;
				l_wa = clr_q;
				if (clr_q == '0)
					h_wd = {IW'(0), IW'(0), IW'(NUM_BLOCKS - 1), 1'b0};
				if (clr_q == IW'(NUM_BLOCKS - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid)
					state_d = S_DEC;
			end
			S_DEC: begin
				if (mode_q == hfa_pkg::MODE_ALLOC) begin
					if (bad_size || !fnd) begin
						state_d = S_DONE;
					end else begin
						hc.rd   = 1'b1;
						lc.rd   = 1'b1;
						h_ra    = heads_q[fb];
						l_ra    = heads_q[fb];
						state_d = S_A_CHK;
					end
				end else begin
					if (bad_off) begin
						state_d = S_DONE;
					end else begin
						hc.rd   = 1'b1;
						h_ra    = idx_d;
						state_d = S_F_I;
					end
				end
			end
			S_A_CHK: begin
				if (h_cnt < blocks_q) begin
					state_d = S_DONE;
				end else begin
					// mark allocated, trim size, point at the split-off rest
					hc.wr      = 1'b1;
					hc.m_size  = 1'b1;
					hc.m_alloc = 1'b1;
					hc.m_next  = (h_cnt != blocks_q);
					h_wa       = cur_q;
					h_wd       = {IW'(0), nb, IW'(blocks_q - BW'(1)), 1'b1};
					ret_d      = S_A_SPL;
					state_d    = S_RM1;
				end
			end
			S_A_SPL: begin
				if (rem_q == '0) begin
					state_d = S_DONE;
				end else begin
					hc      = '{rd: 1'b0, wr: 1'b1, m_prev: 1'b1, m_next: 1'b1,
						m_size: 1'b1, m_alloc: 1'b1};
					h_wa    = nb;
					h_wd    = {cur_q, (nxt_q != cur_q) ? nxt_q : nb,
						IW'(rem_q - BW'(1)), 1'b0};
					state_d = S_A_SPL2;
				end
			end
			S_A_SPL2: begin
				if (nxt_q != cur_q) begin
					hc.wr     = 1'b1;
					hc.m_prev = 1'b1;
					h_wa      = nxt_q;
					h_wd      = {nb, IW'(0), IW'(0), 1'b0};
				end
				state_d = S_INS1;
			end
			S_F_I: begin
				if (!h_alloc) begin
					state_d = S_DONE;
				end else begin
					hc.rd   = 1'b1;
					lc.rd   = 1'b1;
					h_ra    = h_prev;
					l_ra    = h_prev;
					state_d = S_F_P;
				end
			end
			S_F_P: begin
				if (!first_q && !h_alloc) begin
					// lower neighbor absorbs this block: drop its flag
					hc.wr      = 1'b1;
					hc.m_alloc = 1'b1;
					h_wa       = cur_q;
					h_wd       = '0;
					ret_d      = S_F_RN;
					state_d    = S_RM1;
				end else begin
					state_d = S_F_RN;
				end
			end
			S_F_RN: begin
				hc.rd   = 1'b1;
				lc.rd   = 1'b1;
				h_ra    = nxt_q;
				l_ra    = nxt_q;
				state_d = S_F_N;
			end
			S_F_N: begin
				if (!last_q && !h_alloc) begin
					ret_d   = S_F_H1;
					state_d = S_RM1;
				end else begin
					state_d = S_F_H1;
				end
			end
			S_F_H1: begin
				hc.wr      = 1'b1;
				hc.m_next  = 1'b1;
				hc.m_size  = 1'b1;
				hc.m_alloc = 1'b1;
				h_wa       = start_q;
				h_wd       = {IW'(0), fh_next, IW'(sz_q - BW'(1)), 1'b0};
				state_d    = S_F_H2;
			end
			S_F_H2: begin
				if (mrg_n_q && (nn_q != nxt_q)) begin
					hc.wr     = 1'b1;
					hc.m_prev = 1'b1;
					h_wa      = nn_q;
				end else if (!mrg_n_q && !last_q) begin
					hc.wr     = 1'b1;
					hc.m_prev = 1'b1;
					h_wa      = nxt_q;
				end
				h_wd    = {start_q, IW'(0), IW'(0), 1'b0};
				state_d = S_INS1;
			end
			S_RM1: begin
				// unlink: predecessor takes our forward link, or the head moves, or the bucket empties
				if (l_pv) begin
					lc.wr     = 1'b1;
					lc.m_next = 1'b1;
					l_wa      = l_prev;
					l_wd      = l_rd;
				end else if (l_nv) begin
					head_we = 1'b1;
					head_wa = rm_bkt;
					head_wd = l_next;
				end else begin
					nonempty_d[rm_bkt] = 1'b0;
				end
				state_d = S_RM2;
			end
			S_RM2: begin
				if (l_nv) begin
					lc.wr     = 1'b1;
					lc.m_prev = 1'b1;
					l_wa      = l_next;
					l_wd      = l_rd;
				end
				state_d = S_RM3;
			end
			S_RM3: begin
				lc      = '{rd: 1'b0, wr: 1'b1, m_prev: 1'b1, m_next: 1'b1};
				l_wa    = rm_x_q;
				l_wd    = {1'b0, l_prev, 1'b0, l_next};
				state_d = ret_q;
			end
			S_INS1: begin
				// push at the head of its bucket
				lc      = '{rd: 1'b0, wr: 1'b1, m_prev: 1'b1, m_next: 1'b1};
				l_wa    = ins_x_q;
				l_wd    = {1'b0, IW'(0), nonempty_q[ins_bkt],
					nonempty_q[ins_bkt] ? heads_q[ins_bkt] : IW'(0)};
				head_we = 1'b1;
				head_wa = ins_bkt;
				head_wd = ins_x_q;
				nonempty_d[ins_bkt] = 1'b1;
				state_d = nonempty_q[ins_bkt] ? S_INS2 : S_DONE;
			end
			S_INS2: begin
				lc.wr     = 1'b1;
				lc.m_prev = 1'b1;
				l_wa      = ins_h_q;
				l_wd      = {1'b1, ins_x_q, 1'b0, IW'(0)};
				state_d   = S_DONE;
			end
			S_DONE: begin
				// hold until the output register can take the word
				if (!out_valid_q || !out_stall)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			ret_q       <= S_IDLE;
			clr_q       <= '0;
			nonempty_q  <= NUM_BUCKETS'(1) << RST_BKT;
			out_valid_q <= 1'b0;
			for (int k = 0; k < NUM_BUCKETS; k++)
				heads_q[k] <= '0;
		end else begin
			state_q    <= state_d;
			ret_q      <= ret_d;
			nonempty_q <= nonempty_d;
			if (state_q == S_CLR)
				clr_q <= clr_q + IW'(1);
			if (head_we)
				heads_q[head_wa] <= head_wd;
			if ((state_q == S_DONE) && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// request working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mode_q    <= mode;
				bytes_q   <= request_bytes;
				off_q     <= release_offset;
				res_off_q <= '0;
			end
			S_DEC: begin
				blocks_q <= blocks_d;
				cur_q    <= (mode_q == hfa_pkg::MODE_ALLOC) ? heads_q[fb] : idx_d;
				if (mode_q == hfa_pkg::MODE_FREE)
					res_st_q <= hfa_pkg::ST_DONE;
				else if (bad_size)
					res_st_q <= hfa_pkg::ST_SIZE;
				else if (!fnd)
					res_st_q <= hfa_pkg::ST_NOFIT;
				else
					res_st_q <= hfa_pkg::ST_DONE;
			end
			S_A_CHK: begin
				nxt_q     <= h_next;
				rem_q     <= h_cnt - blocks_q;
				rm_x_q    <= cur_q;
				rm_size_q <= h_cnt;
				ins_x_q   <= nb;
				if (h_cnt < blocks_q) begin
					res_st_q <= hfa_pkg::ST_NOFIT;
				end else begin
					res_off_q <= hfa_pkg::OFF_W'((32'(cur_q) << SH) + 32'(HDR));
				end
			end
			S_A_SPL: begin
				ins_size_q <= rem_q;
			end
			S_F_I: begin
				p_q     <= h_prev;
				nxt_q   <= h_next;
				first_q <= (h_prev == cur_q);
				last_q  <= (h_next == cur_q);
				sz_q    <= h_cnt;
				start_q <= cur_q;
			end
			S_F_P: begin
				if (!first_q && !h_alloc) begin
					sz_q      <= sz_q + h_cnt;
					start_q   <= p_q;
					rm_x_q    <= p_q;
					rm_size_q <= h_cnt;
				end
			end
			S_F_N: begin
				mrg_n_q <= !last_q && !h_alloc;
				nn_q    <= h_next;
				if (!last_q && !h_alloc) begin
					sz_q      <= sz_q + h_cnt;
					rm_x_q    <= nxt_q;
					rm_size_q <= h_cnt;
				end
			end
			S_F_H2: begin
				ins_x_q    <= start_q;
				ins_size_q <= sz_q;
			end
			S_INS1: begin
				ins_h_q <= heads_q[ins_bkt];
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					stat_q <= res_st_q;
					poff_q <= res_off_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign status         = stat_q;
	assign payload_offset = poff_q;

`ifndef SYNTHESIS
	// a finished request reaches the output register on the next edge
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) && (!out_valid_q || !out_stall) |=> out_valid_q)
		else $error("result not loaded");

	// a refused request never carries an offset
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status != hfa_pkg::ST_DONE) |-> (payload_offset == '0))
		else $error("offset on refused request");

	// no request is taken during the clearing sweep
	a_clr_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> in_stall && !hc.rd && !lc.rd)
		else $error("activity during clear");

	// the sequencer never reads and writes one memory in the same cycle
	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(hc.rd && hc.wr) && !(lc.rd && lc.wr))
		else $error("memory port conflict");
`endif

endmodule
`default_nettype wire

[bench/half_fit_allocator_test.sv]
// Self-checking bench for the half-fit allocator: directed table, then random traffic.
// Depends on hfa_pkg and half_fit_allocator; carries its own allocator predictor.
`default_nettype none
module half_fit_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import hfa_pkg::*;

	localparam int NBLK = 1024;
	localparam int BBYTES = 32;
	localparam int NBKT = 11;
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic mode;
	logic [OFF_W-1:0] request_bytes;
	logic [OFF_W-1:0] release_offset;
	logic out_valid;
	logic out_stall;
	logic [STAT_W-1:0] status;
	logic [OFF_W-1:0] payload_offset;

	half_fit_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .request_bytes(request_bytes), .release_offset(release_offset),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .payload_offset(payload_offset)
	);

	// predictor state: adjacency chain, free-list links, bucket heads
	typedef struct {
		int prv;
		int nxt;
		int szm1;
		bit used;
	} blk_hdr_t;
	typedef struct {
		bit pv;
		int prv;
		bit nv;
		int nxt;
	} fl_link_t;

	typedef struct packed {
		logic [STAT_W-1:0] st;
		logic [OFF_W-1:0] off;
	} word_t;

	blk_hdr_t hdrs[NBLK];
	fl_link_t links[NBLK];
	int heads[NBKT];
	bit [NBKT-1:0] nonempty;

	word_t pending_words[$];
	int live_offsets[$];
	int mismatches;
	int words_checked;
	longint cycles;
	bit idle_off;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int flog2(int v);
		int b;
		b = 0;
		while (v > 1) begin
			v = v >> 1;
			b++;
		end
		return b;
	endfunction

	function automatic int size_bucket(int blocks);
		int b;
		b = flog2(blocks);
		return (b >= NBKT) ? NBKT - 1 : b;
	endfunction

	function automatic void file_free(int x);
		int b;
		b = size_bucket(hdrs[x].szm1 + 1);
		links[x].pv = 0;
		links[x].prv = 0;
		if (nonempty[b]) begin
			links[x].nv = 1;
			links[x].nxt = heads[b];
			links[heads[b]].pv = 1;
			links[heads[b]].prv = x;
		end else begin
			links[x].nv = 0;
			links[x].nxt = 0;
			nonempty[b] = 1'b1;
		end
		heads[b] = x;
	endfunction

	function automatic void unfile_free(int x);
		int b;
		fl_link_t l;
		b = size_bucket(hdrs[x].szm1 + 1);
		l = links[x];
		if (l.pv) begin
			links[l.prv].nv = l.nv;
			links[l.prv].nxt = l.nxt;
		end else if (l.nv) begin
			heads[b] = l.nxt;
		end else begin
			nonempty[b] = 1'b0;
		end
		if (l.nv) begin
			links[l.nxt].pv = l.pv;
			links[l.nxt].prv = l.prv;
		end
		links[x].pv = 0;
		links[x].nv = 0;
	endfunction

	task automatic heap_reset();
		for (int i = 0; i < NBLK; i++) begin
			hdrs[i] = '{0, 0, 0, 0};
			links[i] = '{0, 0, 0, 0};
		end
		for (int i = 0; i < NBKT; i++)
			heads[i] = 0;
		nonempty = '0;
		hdrs[0].szm1 = NBLK - 1;
		file_free(0);
	endtask

	// allocate: first nonempty bucket at or above the rounded-up size class
	function automatic word_t grant_blocks(int bytes);
		word_t w;
		int blocks, need, b, cur, csize, rem, nb, nx;
		w = '{ST_DONE, '0};
		if (bytes == 0 || bytes > NBLK * BBYTES - HDR_BYTES) begin
			w.st = ST_SIZE;
			return w;
		end
		blocks = (bytes + HDR_BYTES - 1) / BBYTES + 1;
		need = (blocks > 1) ? flog2(blocks - 1) + 1 : 0;
		if (need >= NBKT) begin
			w.st = ST_SIZE;
			return w;
		end
		b = need;
		while (b < NBKT && !nonempty[b])
			b++;
		if (b >= NBKT) begin
			w.st = ST_NOFIT;
			return w;
		end
		cur = heads[b];
		csize = hdrs[cur].szm1 + 1;
		if (csize < blocks) begin
			w.st = ST_NOFIT;
			return w;
		end
		unfile_free(cur);
		rem = csize - blocks;
		hdrs[cur].used = 1;
		hdrs[cur].szm1 = blocks - 1;
		if (rem != 0) begin
			nb = cur + blocks;
			nx = hdrs[cur].nxt;
			hdrs[nb].used = 0;
			hdrs[nb].szm1 = rem - 1;
			hdrs[nb].prv = cur;
			if (nx != cur) begin
				hdrs[nb].nxt = nx;
				hdrs[nx].prv = nb;
			end else begin
				hdrs[nb].nxt = nb;
			end
			hdrs[cur].nxt = nb;
			file_free(nb);
		end
		w.off = OFF_W'(cur * BBYTES + HDR_BYTES);
		return w;
	endfunction

	// free: merge with free neighbors, refile; bad offsets are ignored
	task automatic release_block(int off);
		int idx, p, n, nn, sz, start;
		bit first, last;
		if (off < HDR_BYTES || (off - HDR_BYTES) % BBYTES != 0)
			return;
		idx = (off - HDR_BYTES) / BBYTES;
		if (idx >= NBLK || !hdrs[idx].used)
			return;
		p = hdrs[idx].prv;
		n = hdrs[idx].nxt;
		first = (p == idx);
		last = (n == idx);
		sz = hdrs[idx].szm1 + 1;
		start = idx;
		if (!first && !hdrs[p].used) begin
			unfile_free(p);
			sz += hdrs[p].szm1 + 1;
			hdrs[idx].used = 0;
			start = p;
		end
		if (!last && !hdrs[n].used) begin
			nn = hdrs[n].nxt;
			unfile_free(n);
			sz += hdrs[n].szm1 + 1;
			if (nn == n) begin
				hdrs[start].nxt = start;
			end else begin
				hdrs[start].nxt = nn;
				hdrs[nn].prv = start;
			end
		end else if (last) begin
			hdrs[start].nxt = start;
		end else begin
			hdrs[start].nxt = n;
			hdrs[n].prv = start;
		end
		hdrs[start].used = 0;
		hdrs[start].szm1 = sz - 1;
		file_free(start);
	endtask

	// Hold the word until accepted; idle at random beforehand with valid dropped.
	task automatic send_word(logic m, int bytes, int off);
		while (!idle_off && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		request_bytes <= OFF_W'(bytes);
		release_offset <= OFF_W'(off);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Run one request through the predictor, queue its result, then send it.
	// A typed-in expectation overrides the predictor where given.
	task automatic issue(logic m, int bytes, int off, bit fixed, word_t fixed_word);
		word_t w;
		if (m == MODE_ALLOC) begin
			w = grant_blocks(bytes);
			if (w.st == ST_DONE)
				live_offsets.push_back(w.off);
		end else begin
			w = '{ST_DONE, '0};
			release_block(off);
			foreach (live_offsets[i])
				if (live_offsets[i] == off) begin
					live_offsets.delete(i);
					break;
				end
		end
		if (fixed && fixed_word != w) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table row disagrees with predictor: table %0d/%0d predicted %0d/%0d",
					fixed_word.st, fixed_word.off, w.st, w.off);
		end
		pending_words.push_back(fixed ? fixed_word : w);
		send_word(m, bytes, off);
	endtask

	// Drop valid and wait until every expected word has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	// Output side: stall at random, compare each accepted word to the oldest expectation.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		out_stall <= (!idle_off && $urandom_range(99) < 6);
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: status %0d offset %0d", status, payload_offset);
			end else begin
				if (pending_words[0].st !== status || pending_words[0].off !== payload_offset) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d/%0d got %0d/%0d",
							pending_words[0].st, pending_words[0].off, status, payload_offset);
				end
				void'(pending_words.pop_front());
				words_checked++;
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("half_fit_allocator_test NOT OK");
			$finish;
		end
	end

	// Directed table: mode, bytes, offset, typed-in flag, expected status/offset.
	typedef struct {
		logic m;
		int bytes;
		int off;
		bit fixed;
		logic [STAT_W-1:0] st;
		int exp_off;
	} row_t;

	row_t rows[] = '{
		'{MODE_ALLOC, 0, 0, 1, ST_SIZE, 0},        // size zero
		'{MODE_ALLOC, 32765, 0, 1, ST_SIZE, 0},    // past heap minus header
		'{MODE_ALLOC, 32767, 0, 1, ST_SIZE, 0},
		'{MODE_ALLOC, 28, 0, 1, ST_DONE, 4},       // one block, split from the whole heap
		'{MODE_ALLOC, 29, 0, 1, ST_DONE, 36},      // two blocks
		'{MODE_FREE, 0, 0, 1, ST_DONE, 0},         // below header size
		'{MODE_FREE, 0, 5, 1, ST_DONE, 0},         // misaligned
		'{MODE_FREE, 0, 32740, 1, ST_DONE, 0},     // never allocated
		'{MODE_FREE, 0, 32767, 1, ST_DONE, 0},     // misaligned, inside the last block
		'{MODE_FREE, 0, 4, 1, ST_DONE, 0},
		'{MODE_FREE, 0, 4, 1, ST_DONE, 0},         // double free
		'{MODE_ALLOC, 32764, 0, 1, ST_NOFIT, 0},   // whole heap no longer free
		'{MODE_FREE, 0, 36, 1, ST_DONE, 0},        // merges both sides back
		'{MODE_ALLOC, 32764, 0, 1, ST_DONE, 4},    // whole heap
		'{MODE_ALLOC, 1, 0, 1, ST_NOFIT, 0},       // nothing free
		'{MODE_FREE, 0, 4, 1, ST_DONE, 0},
		'{MODE_ALLOC, 16380, 0, 0, ST_DONE, 0},    // 512 blocks, rest filed low
		'{MODE_ALLOC, 16380, 0, 0, ST_DONE, 0},    // 512 blocks again, taken from the rest
		'{MODE_ALLOC, 16349, 0, 0, ST_DONE, 0},
		'{MODE_FREE, 0, 4, 0, ST_DONE, 0},
		'{MODE_ALLOC, 500, 0, 0, ST_DONE, 0},
		'{MODE_FREE, 0, 16388, 0, ST_DONE, 0}
	};

	initial begin
		int bytes, off, pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_ALLOC;
		request_bytes = '0;
		release_offset = '0;
		out_stall = 1'b0;
		cycles = 0;
		mismatches = 0;
		words_checked = 0;
		idle_off = 1'b0;
		heap_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (rows[i])
			issue(rows[i].m, rows[i].bytes, rows[i].off, rows[i].fixed,
				'{rows[i].st, OFF_W'(rows[i].exp_off)});

		// Random part: mostly valid allocs and frees of live blocks, some noise.
		for (int k = 0; k < 1500; k++) begin
			idle_off = (k >= 600 && k < 800);   // a long stretch with no idling
			if (k == 400 || k == 1000)
				drain_results();                // hold the sender until all words land
			pick = $urandom_range(99);
			if (pick < 45) begin
				case ($urandom_range(9))
					0: bytes = $urandom_range(32767);
					1: bytes = $urandom_range(4095, 1024);
					default: bytes = $urandom_range(300, 1);
				endcase
				issue(MODE_ALLOC, bytes, $urandom_range(32767), 0, '{ST_DONE, '0});
			end else if (pick < 88 && live_offsets.size() != 0) begin
				off = live_offsets[$urandom_range(live_offsets.size() - 1)];
				issue(MODE_FREE, $urandom_range(32767), off, 0, '{ST_DONE, '0});
			end else begin
				issue(MODE_FREE, $urandom_range(32767), $urandom_range(32767), 0,
					'{ST_DONE, '0});
			end
		end

		drain_results();
		repeat (40) @(posedge clk);
		$display("covered %0d words: size and fit refusals, splits, merges, bad frees",
			words_checked);
		if (mismatches == 0 && pending_words.size() == 0) begin
			$display("half_fit_allocator_test OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("half_fit_allocator_test NOT OK");
		end
		$finish;
	end

endmodule
`default_nettype wire

[half_fit_allocator.f]
rtl/hfa_pkg.sv
rtl/hfa_store.sv
rtl/half_fit_allocator.sv
bench/half_fit_allocator_test.sv
